FILE: src/periodic_task_deadline_dispatcher_defines.svh
// Assertion macros shared by the dispatcher modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef PERIODIC_TASK_DEADLINE_DISPATCHER_DEFINES_SVH
`define PERIODIC_TASK_DEADLINE_DISPATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ptdd_pkg.sv
// Shared types and constants for the periodic task deadline dispatcher.
// Used by ptdd_ctrl, ptdd_datapath and the top level; depends on nothing.
package ptdd_pkg;

    localparam int MAX_TASKS_DEF = 4;
    localparam int TIME_BITS_DEF = 32;

    localparam int NUM_INTERVALS = 4;
    localparam int INTERVAL_W    = 16;
    localparam int TASK_COUNT_W  = 3;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int ADVANCE_W     = 8;
    localparam int ACTION_W      = 1;
    localparam int OUT_INDEX_W   = 2;
    localparam int OUT_TIME_W    = 32;
    localparam int M_TDATA_W     = 72;
    localparam int MAX_RESULTS   = 4;
    localparam int CNT_W         = 2;

    localparam logic [ACTION_W-1:0] ACT_START   = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TASK_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL0  = 3'd1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET [NUM_INTERVALS] =
        '{16'd100, 16'd200, 16'd500, 16'd1000};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARM,
        ST_ADVANCE,
        ST_CALC,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic arm;
        logic advance;
        logic calc;
        logic scan_clear;
        logic scan_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic armed;
        logic scan_end;
        logic best_valid;
        logic out_free;
        logic last;
    } dp_status_t;

endpackage

FILE: src/periodic_task_deadline_dispatcher.sv
// Periodic task deadline dispatcher (earliest-deadline timer queue), top level.
// Uses ptdd_pkg, ptdd_ctrl and ptdd_datapath.
//
// Input items arrive on the s_ stream: s_tuser is the action (start or advance),
// s_tdata the advance amount. A start arms every enabled task at now plus its
// interval and gives no result. An advance adds to the time and emits one result
// per due task on the m_ stream, soonest deadline first, at most four, with m_tlast
// on the final one. The cfg_ channel writes the task count and the four intervals;
// cfg_ready is always high. Configure only while the block is idle.
// Steps: a start passes through the arm state, and an advance before any start
// through the advance state only. An armed advance goes through advance and calc,
// then, for each result, a deadline scan over all MAX_TASKS slots and an emit step;
// with no due task it ends after one empty scan. The serial scan, one age compare
// per cycle, sets the pace of results. One item is handled at a time.
// The next item is taken while the last result still sits in the output register.
// If the receiver stalls, the block holds in its emit step until the register frees.
// Reset clears time, the armed flag, the task count and restores default intervals;
// deadlines hold no value until the first start.

module periodic_task_deadline_dispatcher
#(
    parameter int MAX_TASKS = ptdd_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = ptdd_pkg::TIME_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ptdd_pkg::ADVANCE_W-1:0]      s_tdata,   // [7:0] advance
    input  logic [ptdd_pkg::ACTION_W-1:0]       s_tuser,   // [0] action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] task_index, [33:2] due_time, [65:34] dispatch_time, [71:66] zero
    output logic [ptdd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptdd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ptdd_pkg::ctrl_cmd_t  cmd;
    ptdd_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    ptdd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    ptdd_datapath
    #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: src/ptdd_ctrl.sv
// Controller state machine of the dispatcher: sequences arm, advance, scan and emit.
// Depends on ptdd_pkg and periodic_task_deadline_dispatcher_defines.svh.
`include "periodic_task_deadline_dispatcher_defines.svh"

module ptdd_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ptdd_pkg::ACTION_W-1:0]       s_tuser,
    input  ptdd_pkg::dp_status_t                status,
    output ptdd_pkg::ctrl_cmd_t                 cmd
);

    ptdd_pkg::state_t state_reg;
    ptdd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptdd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ptdd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tuser == ptdd_pkg::ACT_START)
                    begin
                        state_next = ptdd_pkg::ST_ARM;
                    end
                    else
                    begin
                        state_next = ptdd_pkg::ST_ADVANCE;
                    end
                end
            end
            ptdd_pkg::ST_ARM:
            begin
                cmd.arm    = 1'b1;
                state_next = ptdd_pkg::ST_IDLE;
            end
            ptdd_pkg::ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                if (status.armed)
                begin
                    state_next = ptdd_pkg::ST_CALC;
                end
                else
                begin
                    state_next = ptdd_pkg::ST_IDLE;
                end
            end
            ptdd_pkg::ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ptdd_pkg::ST_SCAN;
            end
            ptdd_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_end)
                begin
                    state_next = ptdd_pkg::ST_EMIT;
                end
            end
            ptdd_pkg::ST_EMIT:
            begin
                if (!status.best_valid)
                begin
                    state_next = ptdd_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                    begin
                        state_next = ptdd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ptdd_pkg::ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ptdd_pkg::ST_IDLE;
            end
        endcase
    end

    `PTDD_ASSERT_NOW(a_emit_has_room, cmd.emit, status.out_free && status.best_valid,
        "Result emitted without a selected task or a free output register")
    `PTDD_ASSERT_NEXT(a_last_goes_idle, cmd.emit && status.last,
        state_reg == ptdd_pkg::ST_IDLE, "Controller did not return to idle after last result")

endmodule

FILE: src/ptdd_datapath.sv
// Datapath of the dispatcher: configuration, time, deadlines, scan unit and output register.
// Depends on ptdd_pkg and periodic_task_deadline_dispatcher_defines.svh.
`include "periodic_task_deadline_dispatcher_defines.svh"

module ptdd_datapath
#(
    parameter int MAX_TASKS = ptdd_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = ptdd_pkg::TIME_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ptdd_pkg::ADVANCE_W-1:0]      s_tdata,
    input  logic                                cfg_valid,
    input  logic [ptdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptdd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ptdd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  ptdd_pkg::ctrl_cmd_t                 cmd,
    output ptdd_pkg::dp_status_t                status
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic [ptdd_pkg::TASK_COUNT_W-1:0] task_count_reg;
    logic [ptdd_pkg::INTERVAL_W-1:0]   interval_reg [ptdd_pkg::NUM_INTERVALS];
    logic [ptdd_pkg::ADVANCE_W-1:0]    adv_reg;
    logic [TIME_BITS-1:0]              time_reg;
    logic                              armed_reg;
    logic [TIME_BITS-1:0]              deadline_reg [MAX_TASKS];
    logic [TIME_BITS-1:0]              age_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0]              due_reg;
    logic [IDX_W-1:0]                  scan_idx_reg;
    logic [IDX_W-1:0]                  best_reg;
    logic [TIME_BITS-1:0]              best_age_reg;
    logic                              best_valid_reg;
    logic [ptdd_pkg::CNT_W-1:0]        cnt_reg;

    logic                              m_tvalid_reg;
    logic [ptdd_pkg::OUT_INDEX_W-1:0]  m_index_reg;
    logic [ptdd_pkg::OUT_TIME_W-1:0]   m_due_reg;
    logic [ptdd_pkg::OUT_TIME_W-1:0]   m_disp_reg;
    logic                              m_last_reg;

    logic [ptdd_pkg::INTERVAL_W-1:0]   iv [MAX_TASKS];
    logic [TIME_BITS-1:0]              age_now [MAX_TASKS];
    logic [MAX_TASKS-1:0]              enabled;
    logic [MAX_TASKS-1:0]              due_rest;
    logic                              take;
    logic                              last;
    logic                              out_free;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_task
            logic [ptdd_pkg::INTERVAL_W-1:0] raw;
            if (g < ptdd_pkg::NUM_INTERVALS)
            begin : g_reg
                assign raw = interval_reg[g];
            end
            else
            begin : g_none
                assign raw = '0;
            end
            assign iv[g]      = (raw == '0) ? ptdd_pkg::INTERVAL_W'(1) : raw;
            assign enabled[g] = (task_count_reg >= ptdd_pkg::TASK_COUNT_W'(g + 1));
            assign age_now[g] = time_reg - deadline_reg[g];
        end
    endgenerate

    assign out_free = !m_tvalid_reg || m_tready;
    assign take     = due_reg[scan_idx_reg]
                      && (!best_valid_reg || (age_reg[scan_idx_reg] > best_age_reg));
    assign due_rest = due_reg & ~(MAX_TASKS'(1) << best_reg);
    assign last     = (cnt_reg == ptdd_pkg::CNT_W'(ptdd_pkg::MAX_RESULTS - 1))
                      || (due_rest == '0);

    assign status.armed      = armed_reg;
    assign status.scan_end   = (scan_idx_reg == IDX_W'(MAX_TASKS - 1));
    assign status.best_valid = best_valid_reg;
    assign status.out_free   = out_free;
    assign status.last       = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            for (int i = 0; i < ptdd_pkg::NUM_INTERVALS; i++)
            begin
                interval_reg[i] <= ptdd_pkg::INTERVAL_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ptdd_pkg::CFG_TASK_COUNT)
            begin
                task_count_reg <= cfg_data[ptdd_pkg::TASK_COUNT_W-1:0];
            end
            for (int i = 0; i < ptdd_pkg::NUM_INTERVALS; i++)
            begin
                if (cfg_index == ptdd_pkg::CFG_INTERVAL0 + ptdd_pkg::CFG_INDEX_W'(i))
                begin
                    interval_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            armed_reg      <= 1'b0;
            due_reg        <= '0;
            scan_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.advance)
            begin
                time_reg <= time_reg + TIME_BITS'(adv_reg);
            end
            if (cmd.arm)
            begin
                armed_reg <= 1'b1;
            end
            if (cmd.calc || cmd.scan_clear)
            begin
                scan_idx_reg   <= '0;
                best_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (!status.scan_end)
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                if (take)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
            if (cmd.calc)
            begin
                cnt_reg <= '0;
                for (int i = 0; i < MAX_TASKS; i++)
                begin
                    due_reg[i] <= enabled[i] && !age_now[i][TIME_BITS-1];
                end
            end
            else if (cmd.emit)
            begin
                cnt_reg  <= cnt_reg + ptdd_pkg::CNT_W'(1);
                due_reg  <= due_rest;
            end
            if (cmd.emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            adv_reg <= s_tdata;
        end
        if (cmd.calc)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                age_reg[i] <= age_now[i];
            end
        end
        if (cmd.scan_step && take)
        begin
            best_reg     <= scan_idx_reg;
            best_age_reg <= age_reg[scan_idx_reg];
        end
        if (cmd.arm)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                if (enabled[i])
                begin
                    deadline_reg[i] <= time_reg + TIME_BITS'(iv[i]);
                end
            end
        end
        else if (cmd.emit)
        begin
            deadline_reg[best_reg] <= time_reg + TIME_BITS'(iv[best_reg]);
        end
        if (cmd.emit)
        begin
            m_index_reg <= ptdd_pkg::OUT_INDEX_W'(best_reg);
            m_due_reg   <= ptdd_pkg::OUT_TIME_W'(deadline_reg[best_reg]);
            m_disp_reg  <= ptdd_pkg::OUT_TIME_W'(time_reg);
            m_last_reg  <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {
        {(ptdd_pkg::M_TDATA_W - ptdd_pkg::OUT_INDEX_W - 2 * ptdd_pkg::OUT_TIME_W){1'b0}},
        m_disp_reg, m_due_reg, m_index_reg
    };

    `PTDD_ASSERT_NEXT(a_time_only_on_advance, !cmd.advance, $stable(time_reg),
        "Time changed without an advance command")
    `PTDD_ASSERT_NEXT(a_emit_fills_output, cmd.emit,
        m_tvalid_reg && (cnt_reg != $past(cnt_reg)),
        "Emit did not load the output register or count the dispatch")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for periodic_task_deadline_dispatcher: directed and random start and
// advance items under varying backpressure, checked against an earliest-deadline predictor.
// Depends on ptdd_pkg and the dispatcher RTL only.
module testbench;
    import ptdd_pkg::*;

    localparam int HOLD_CYCLES          = 400;
    localparam int SETTLE_CYCLES        = 16;
    localparam int WATCHDOG_LIMIT       = 4000;
    localparam int MAX_MISMATCH_REPORTS = 10;
    localparam int RANDOM_SEGMENTS      = 6;
    localparam int ITEMS_PER_SEGMENT    = 18;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED =
        CFG_INDEX_W'(CFG_INTERVAL0 + NUM_INTERVALS);

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] task_index;
        logic [OUT_TIME_W-1:0]  due_time;
        logic [OUT_TIME_W-1:0]  dispatch_time;
        logic                   last_dispatch;
    } dispatch_t;

    class dispatch_scoreboard;
        bit [OUT_TIME_W-1:0]   now_time;
        bit [OUT_TIME_W-1:0]   deadline [MAX_TASKS_DEF];
        bit                    deadline_set [MAX_TASKS_DEF];
        bit                    armed;
        bit [TASK_COUNT_W-1:0] task_count;
        bit [INTERVAL_W-1:0]   interval [NUM_INTERVALS];
        dispatch_t             due_dispatches [$];
        int unsigned           failures;
        int unsigned           items_seen;
        int unsigned           dispatches_seen;
        int unsigned           registers_written;

        function new();
            int i;
            now_time          = '0;
            armed             = 1'b0;
            task_count        = '0;
            failures          = 0;
            items_seen        = 0;
            dispatches_seen   = 0;
            registers_written = 0;
            for (i = 0; i < MAX_TASKS_DEF; i++)
            begin
                deadline[i]     = '0;
                deadline_set[i] = 1'b0;
            end
            for (i = 0; i < NUM_INTERVALS; i++)
                interval[i] = INTERVAL_RESET[i];
        endfunction

        function int enabled_count();
            int n;
            n = int'(task_count);
            if (n > MAX_TASKS_DEF)
                n = MAX_TASKS_DEF;
            return n;
        endfunction

        function bit [OUT_TIME_W-1:0] period(int i);
            if (interval[i] == '0)
                return OUT_TIME_W'(1);
            return OUT_TIME_W'(interval[i]);
        endfunction

        function int pending();
            return due_dispatches.size();
        endfunction

        function bit needs_rearm();
            int i;
            bit missing;
            missing = 1'b0;
            for (i = 0; i < enabled_count(); i++)
                if (!deadline_set[i])
                    missing = 1'b1;
            return armed && missing;
        endfunction

        function void note_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            registers_written++;
            if (idx == CFG_TASK_COUNT)
                task_count = data[TASK_COUNT_W-1:0];
            else if (idx >= CFG_INTERVAL0 && idx < CFG_UNUSED)
                interval[idx - CFG_INTERVAL0] = data;
        endfunction

        function void note_item(logic [ACTION_W-1:0] act, logic [ADVANCE_W-1:0] adv);
            bit [OUT_TIME_W-1:0] age [MAX_TASKS_DEF];
            bit                  waiting [MAX_TASKS_DEF];
            dispatch_t           rec;
            dispatch_t           batch [$];
            int                  n;
            int                  i;
            int                  best;
            n = enabled_count();
            items_seen++;
            if (act == ACT_START)
            begin
                for (i = 0; i < n; i++)
                begin
                    deadline[i]     = now_time + period(i);
                    deadline_set[i] = 1'b1;
                end
                armed = 1'b1;
                return;
            end
            now_time = now_time + OUT_TIME_W'(adv);
            if (!armed)
                return;
            for (i = 0; i < MAX_TASKS_DEF; i++)
            begin
                age[i]     = now_time - deadline[i];
                waiting[i] = (i < n) && !age[i][OUT_TIME_W-1];
            end
            // A larger age means an earlier deadline; ties keep the lower index.
            do
            begin
                best = -1;
                for (i = 0; i < MAX_TASKS_DEF; i++)
                begin
                    if (waiting[i])
                    begin
                        if (best < 0)
                            best = i;
                        else if (age[i] > age[best])
                            best = i;
                    end
                end
                if (best >= 0)
                begin
                    waiting[best]      = 1'b0;
                    rec.task_index     = OUT_INDEX_W'(best);
                    rec.due_time       = deadline[best];
                    rec.dispatch_time  = now_time;
                    rec.last_dispatch  = 1'b0;
                    batch.push_back(rec);
                    deadline[best] = now_time + period(best);
                end
            end
            while (best >= 0);
            if (batch.size() > 0)
                batch[batch.size() - 1].last_dispatch = 1'b1;
            foreach (batch[k])
                due_dispatches.push_back(batch[k]);
        endfunction

        function void check_dispatch(logic [M_TDATA_W-1:0] tdata, logic tlast);
            dispatch_t got;
            dispatch_t want;
            got.task_index    = tdata[OUT_INDEX_W-1:0];
            got.due_time      = tdata[OUT_INDEX_W +: OUT_TIME_W];
            got.dispatch_time = tdata[OUT_INDEX_W + OUT_TIME_W +: OUT_TIME_W];
            got.last_dispatch = tlast;
            dispatches_seen++;
            if (due_dispatches.size() == 0)
            begin
                failures++;
                if (failures <= MAX_MISMATCH_REPORTS)
                    $display("unexpected dispatch: task %0d due %0d at %0d last %0b",
                             got.task_index, got.due_time, got.dispatch_time,
                             got.last_dispatch);
                return;
            end
            want = due_dispatches.pop_front();
            if (got.task_index !== want.task_index || got.due_time !== want.due_time ||
                got.dispatch_time !== want.dispatch_time ||
                got.last_dispatch !== want.last_dispatch)
            begin
                failures++;
                if (failures <= MAX_MISMATCH_REPORTS)
                    $display("dispatch mismatch: expected task %0d due %0d at %0d last %0b, %s",
                             want.task_index, want.due_time, want.dispatch_time,
                             want.last_dispatch,
                             $sformatf("got task %0d due %0d at %0d last %0b",
                                       got.task_index, got.due_time, got.dispatch_time,
                                       got.last_dispatch));
            end
        endfunction

        function void finish_check();
            if (due_dispatches.size() > 0)
            begin
                failures += due_dispatches.size();
                $display("%0d expected dispatches never arrived", due_dispatches.size());
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ADVANCE_W-1:0]   s_tdata;    // [7:0] advance
    logic [ACTION_W-1:0]    s_tuser;    // [0] action
    logic                   m_tvalid;
    logic                   m_tready;
    // [1:0] task_index, [33:2] due_time, [65:34] dispatch_time, [71:66] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int unsigned        sender_idle_pct;
    int unsigned        receiver_idle_pct;
    bit                 hold_req;
    dispatch_scoreboard board = new();

    periodic_task_deadline_dispatcher DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ADVANCE_W-1:0] adv);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= adv;
        do @(posedge clk); while (!s_tready);
        board.note_item(act, adv);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.note_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // An advance that dispatches nothing can still be scanning after the last
    // result, so the extra cycles cover one full empty scan.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_item();
        logic [ACTION_W-1:0]  act;
        logic [ADVANCE_W-1:0] adv;
        act = ($urandom_range(0, 9) == 0) ? ACT_START : ACT_ADVANCE;
        if (board.needs_rearm())
            act = ACT_START;
        case ($urandom_range(0, 3))
            0:       adv = ADVANCE_W'($urandom_range(0, 7));
            1:       adv = ADVANCE_W'($urandom_range(248, 255));
            default: adv = ADVANCE_W'($urandom);
        endcase
        send_item(act, adv);
    endtask

    task automatic configure_random();
        logic [CFG_DATA_W-1:0] count_word;
        logic [INTERVAL_W-1:0] iv;
        bit                    count_first;
        int                    k;
        count_word = CFG_DATA_W'($urandom);
        count_word[TASK_COUNT_W-1:0] = TASK_COUNT_W'($urandom_range(1, 7));
        count_first = 1'($urandom_range(0, 1));
        if (count_first)
            write_register(CFG_TASK_COUNT, count_word);
        for (k = 0; k < NUM_INTERVALS; k++)
        begin
            case ($urandom_range(0, 7))
                0:       iv = '0;
                1:       iv = '1;
                2:       iv = INTERVAL_W'($urandom_range(1, 4));
                default: iv = INTERVAL_W'($urandom_range(1, 400));
            endcase
            write_register(CFG_INDEX_W'(CFG_INTERVAL0 + k), iv);
        end
        write_register(CFG_INDEX_W'(CFG_UNUSED + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
        if (!count_first)
            write_register(CFG_TASK_COUNT, count_word);
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_dispatch(m_tdata, m_tlast);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial
    begin : stimulus
        int seg;
        int k;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_START;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        hold_req          = 1'b0;
        sender_idle_pct   = 37;
        receiver_idle_pct = 88;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Time moves before any start, but nothing may be dispatched.
        send_item(ACT_ADVANCE, 8'd0);
        send_item(ACT_ADVANCE, 8'd255);
        send_item(ACT_START, 8'h5A);
        send_item(ACT_ADVANCE, 8'hA5);
        settle();

        write_register(CFG_TASK_COUNT, 16'd4);
        send_item(ACT_START, 8'h55);
        send_item(ACT_ADVANCE, 8'd100);
        send_item(ACT_ADVANCE, 8'd255);
        send_item(ACT_ADVANCE, 8'd255);
        settle();

        // Zero and extreme periods, with an over-range task count that saturates.
        write_register(CFG_INTERVAL0, 16'd0);
        write_register(CFG_INTERVAL0 + 3'd1, 16'd1);
        write_register(CFG_INTERVAL0 + 3'd2, 16'hFFFF);
        write_register(CFG_INTERVAL0 + 3'd3, 16'd2);
        write_register(CFG_UNUSED, 16'hFFFF);
        write_register(CFG_UNUSED + 3'd2, 16'h1234);
        write_register(CFG_TASK_COUNT, 16'hFFFF);
        send_item(ACT_START, 8'd0);
        send_item(ACT_ADVANCE, 8'd0);
        send_item(ACT_ADVANCE, 8'd1);
        send_item(ACT_ADVANCE, 8'd1);
        send_item(ACT_ADVANCE, 8'd255);
        settle();

        // Equal periods give equal deadlines, so index order decides.
        write_register(CFG_INTERVAL0 + 3'd2, 16'd1);
        write_register(CFG_INTERVAL0 + 3'd3, 16'd1);
        send_item(ACT_START, 8'd0);
        send_item(ACT_ADVANCE, 8'd1);
        send_item(ACT_ADVANCE, 8'd1);
        settle();

        write_register(CFG_TASK_COUNT, 16'd2);
        send_item(ACT_ADVANCE, 8'd10);
        settle();
        write_register(CFG_TASK_COUNT, 16'd0);
        send_item(ACT_ADVANCE, 8'd5);

        for (seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                sender_idle_pct   = 88;
                receiver_idle_pct = 37;
            end
            if (seg == 4)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            settle();
            configure_random();
            if (seg == 4)
                hold_req = 1'b1;
            for (k = 0; k < ITEMS_PER_SEGMENT; k++)
                random_item();
        end
        settle();
        board.finish_check();

        $display("covered %0d items, %0d dispatches and %0d register writes",
                 board.items_seen, board.dispatches_seen, board.registers_written);
        $display("under three idle patterns and a %0d-cycle receiver hold", HOLD_CYCLES);
        if (board.failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

FILE: periodic_task_deadline_dispatcher.f
+incdir+src
src/ptdd_pkg.sv
src/ptdd_ctrl.sv
src/ptdd_datapath.sv
src/periodic_task_deadline_dispatcher.sv
tb/sv/testbench.sv
